@@ rtl/u8n1_pkg.sv @@
// ----------------------------------------------------------------------------
// u8n1_pkg
// Shared constants and types for the 8N1 UART transceiver.
// ----------------------------------------------------------------------------
package u8n1_pkg;

    localparam int RX_FIFO_DEPTH = 16;
    localparam int PTR_W         = $clog2(RX_FIFO_DEPTH);
    localparam int FILL_W        = $clog2(RX_FIFO_DEPTH + 1);
    localparam int COUNT_W       = 5;

    localparam int PERIOD_W      = 16;
    localparam int RX_TIMER_W    = 17;
    localparam int BITS_W        = 4;
    localparam int BYTE_W        = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd139;

    // tx frame: eight data bits then the stop bit
    localparam logic [BITS_W-1:0] TX_FRAME_BITS = 4'd9;
    localparam logic [BITS_W-1:0] RX_DATA_BITS  = 4'd8;

    // APB register map (word index = paddr[2])
    localparam int   PADDR_W        = 3;
    localparam logic REG_BIT_PERIOD = 1'b0;

    localparam int IN_FIELDS_W  = 11;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_FIELDS_W = 18;
    localparam int OUT_TDATA_W  = 24;

    typedef struct packed {
        logic line;
        logic busy;
        logic accepted;
    } tx_status_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rx_push_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } fifo_status_t;

endpackage

@@ rtl/u8n1_tx.sv @@
// ----------------------------------------------------------------------------
// u8n1_tx
// Transmit side: start bit, eight data bits LSB first, stop bit; busy ends
// with the stop bit.
// ----------------------------------------------------------------------------
module u8n1_tx (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            start,
    input  logic [u8n1_pkg::BYTE_W-1:0]     byte_in,
    input  logic [u8n1_pkg::PERIOD_W-1:0]   bit_period,
    output u8n1_pkg::tx_status_t            status
);

    logic [u8n1_pkg::PERIOD_W-1:0] timer_reg, timer_next;
    logic [u8n1_pkg::BYTE_W-1:0]   shift_reg, shift_next;
    logic [u8n1_pkg::BITS_W-1:0]   bits_left_reg, bits_left_next;
    logic                          active_reg, active_next;
    logic                          level_reg, level_next;
    logic                          accepted;
    logic                          fire;

    assign fire = (timer_reg <= u8n1_pkg::PERIOD_W'(1));

    always_comb
    begin
        timer_next     = timer_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        active_next    = active_reg;
        level_next     = level_reg;
        accepted       = 1'b0;
        if (!active_reg)
        begin
            if (start)
            begin
                accepted       = 1'b1;
                active_next    = 1'b1;
                shift_next     = byte_in;
                bits_left_next = u8n1_pkg::TX_FRAME_BITS;
                level_next     = 1'b0;
                timer_next     = bit_period;
            end
        end
        else if (fire)
        begin
            if (bits_left_reg > u8n1_pkg::BITS_W'(1))
            begin
                level_next     = shift_reg[0];
                shift_next     = {1'b0, shift_reg[u8n1_pkg::BYTE_W-1:1]};
                bits_left_next = bits_left_reg - u8n1_pkg::BITS_W'(1);
                timer_next     = bit_period;
            end
            else if (bits_left_reg == u8n1_pkg::BITS_W'(1))
            begin
                // stop bit
                level_next     = 1'b1;
                bits_left_next = '0;
                timer_next     = bit_period;
            end
            else
            begin
                active_next = 1'b0;
                level_next  = 1'b1;
            end
        end
        else
        begin
            timer_next = timer_reg - u8n1_pkg::PERIOD_W'(1);
        end
    end

    always_comb
    begin
        status.line     = level_next;
        status.busy     = active_next;
        status.accepted = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg     <= '0;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            active_reg    <= 1'b0;
            level_reg     <= 1'b1;
        end
        else if (step)
        begin
            timer_reg     <= timer_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            active_reg    <= active_next;
            level_reg     <= level_next;
        end
    end

endmodule

@@ rtl/u8n1_rx.sv @@
// ----------------------------------------------------------------------------
// u8n1_rx
// Receive side: falling-edge start detect, first sample 1.5 periods later,
// then one sample per period until eight bits are in.
// ----------------------------------------------------------------------------
module u8n1_rx (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            line,
    input  logic [u8n1_pkg::PERIOD_W-1:0]   bit_period,
    output u8n1_pkg::rx_push_t              push
);

    logic [u8n1_pkg::RX_TIMER_W-1:0] timer_reg, timer_next;
    logic [u8n1_pkg::BYTE_W-1:0]     shift_reg, shift_next;
    logic [u8n1_pkg::BITS_W-1:0]     bits_got_reg, bits_got_next;
    logic                            active_reg, active_next;
    logic                            prev_reg;
    logic                            fire;

    assign fire = (timer_reg <= u8n1_pkg::RX_TIMER_W'(1));

    always_comb
    begin
        timer_next    = timer_reg;
        shift_next    = shift_reg;
        bits_got_next = bits_got_reg;
        active_next   = active_reg;
        push.valid    = 1'b0;
        push.data     = '0;
        if (active_reg)
        begin
            if (fire)
            begin
                shift_next    = {line, shift_reg[u8n1_pkg::BYTE_W-1:1]};
                bits_got_next = bits_got_reg + u8n1_pkg::BITS_W'(1);
                timer_next    = u8n1_pkg::RX_TIMER_W'(bit_period);
                if (bits_got_next >= u8n1_pkg::RX_DATA_BITS)
                begin
                    push.valid  = 1'b1;
                    push.data   = shift_next;
                    active_next = 1'b0;
                end
            end
            else
            begin
                timer_next = timer_reg - u8n1_pkg::RX_TIMER_W'(1);
            end
        end
        else if (prev_reg && !line)
        begin
            // start edge: first sample lands mid data bit 0
            active_next   = 1'b1;
            timer_next    = u8n1_pkg::RX_TIMER_W'(bit_period)
                          + u8n1_pkg::RX_TIMER_W'(bit_period[u8n1_pkg::PERIOD_W-1:1]);
            bits_got_next = '0;
            shift_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg    <= '0;
            shift_reg    <= '0;
            bits_got_reg <= '0;
            active_reg   <= 1'b0;
            prev_reg     <= 1'b1;
        end
        else if (step)
        begin
            timer_reg    <= timer_next;
            shift_reg    <= shift_next;
            bits_got_reg <= bits_got_next;
            active_reg   <= active_next;
            prev_reg     <= line;
        end
    end

endmodule

@@ rtl/u8n1_fifo.sv @@
// ----------------------------------------------------------------------------
// u8n1_fifo
// Receive FIFO: pop before push in the same tick, push to full is dropped.
// ----------------------------------------------------------------------------
module u8n1_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    pop,
    input  u8n1_pkg::rx_push_t      push,
    output u8n1_pkg::fifo_status_t  status
);

    logic [u8n1_pkg::BYTE_W-1:0] mem_reg [u8n1_pkg::RX_FIFO_DEPTH];
    logic [u8n1_pkg::PTR_W-1:0]  head_reg, head_next;
    logic [u8n1_pkg::PTR_W-1:0]  tail_reg, tail_next;
    logic [u8n1_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [u8n1_pkg::FILL_W-1:0] fill_after_pop;
    logic                        do_pop;
    logic                        do_push;
    logic                        full;

    localparam logic [u8n1_pkg::PTR_W-1:0] LAST_PTR =
        u8n1_pkg::PTR_W'(u8n1_pkg::RX_FIFO_DEPTH - 1);

    always_comb
    begin
        do_pop         = pop && (fill_reg != '0);
        fill_after_pop = fill_reg - u8n1_pkg::FILL_W'(do_pop);
        full           = (fill_after_pop == u8n1_pkg::FILL_W'(u8n1_pkg::RX_FIFO_DEPTH));
        do_push        = push.valid && !full;
        fill_next      = fill_after_pop + u8n1_pkg::FILL_W'(do_push);

        head_next = head_reg;
        if (do_pop)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + u8n1_pkg::PTR_W'(1);
        end
        tail_next = tail_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + u8n1_pkg::PTR_W'(1);
        end

        status.data     = do_pop ? mem_reg[head_reg] : '0;
        status.valid    = do_pop;
        status.count    = u8n1_pkg::COUNT_W'(fill_next);
        status.overflow = push.valid && full;
    end

    always_ff @(posedge clk)
    begin
        if (step && do_push)
        begin
            mem_reg[tail_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else if (step)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ rtl/uart_8n1_transceiver.sv @@
// ----------------------------------------------------------------------------
// uart_8n1_transceiver
// 8N1 UART transceiver stepped one clock tick per input transfer.
// ----------------------------------------------------------------------------
//  port group   dir   contents
//  s_axis_*     in    one tick: tx_start, tx_byte, rx_line, rx_pop
//  m_axis_*     out   tick result: line/busy/accept, popped byte, fifo count
//  APB          in    bit_period at word 0
//
//  One transfer per cycle sustained while m_axis is ready; each input transfer
//  passes through the input register, then the result register.
//  Reset puts both lines idle, the FIFO empty and bit_period at 139.
//  A stall on m_axis holds the result register, then the input register,
//  and the bit timers only advance when a tick moves into the result stage.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] tx_start, [8:1] tx_byte, [9] rx_line, [10] rx_pop, [15:11] zero
    input  logic [u8n1_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] tx_line, [1] tx_busy, [2] tx_accepted, [10:3] rx_byte, [11] rx_valid,
    // [16:12] rx_count, [17] rx_overflow, [23:18] zero
    output logic [u8n1_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [u8n1_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [u8n1_pkg::PERIOD_W-1:0]     bit_period_reg;
    logic                              in_valid_reg;
    logic [u8n1_pkg::IN_FIELDS_W-1:0]  in_data_reg;
    logic                              out_valid_reg;
    logic [u8n1_pkg::OUT_FIELDS_W-1:0] out_data_reg, out_data_next;
    logic                              advance;
    logic                              step;
    logic                              cfg_write;

    u8n1_pkg::tx_status_t   tx_status;
    u8n1_pkg::rx_push_t     rx_push;
    u8n1_pkg::fifo_status_t fifo_status;

    // ---- configuration ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == u8n1_pkg::REG_BIT_PERIOD) ? 32'(bit_period_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= u8n1_pkg::PERIOD_RESET;
        end
        else if (cfg_write && paddr[2] == u8n1_pkg::REG_BIT_PERIOD)
        begin
            bit_period_reg <= pwdata[u8n1_pkg::PERIOD_W-1:0];
        end
    end

    // ---- two-stage pipeline ----
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[u8n1_pkg::IN_FIELDS_W-1:0];
        end
    end

    u8n1_tx u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .start      (in_data_reg[0]),
        .byte_in    (in_data_reg[8:1]),
        .bit_period (bit_period_reg),
        .status     (tx_status)
    );

    u8n1_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .line       (in_data_reg[9]),
        .bit_period (bit_period_reg),
        .push       (rx_push)
    );

    u8n1_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .pop    (in_data_reg[10]),
        .push   (rx_push),
        .status (fifo_status)
    );

    assign out_data_next = {fifo_status.overflow, fifo_status.count, fifo_status.valid,
                            fifo_status.data, tx_status.accepted, tx_status.busy,
                            tx_status.line};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = u8n1_pkg::OUT_TDATA_W'(out_data_reg);

    // ---- checks ----
    // accepted frame starts busy with the line driven low
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[2] |-> out_data_reg[1] && !out_data_reg[0])
        else $error("accepted transfer without busy start bit");

    // a pop in the same tick always frees room for the push
    a_overflow_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[17] |-> !out_data_reg[11])
        else $error("overflow reported in a tick with a successful pop");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[17]
        |-> out_data_reg[16:12] == u8n1_pkg::COUNT_W'(u8n1_pkg::RX_FIFO_DEPTH))
        else $error("overflow reported with FIFO not full");

    // a stalled result stage must keep the input stage from stepping
    a_stall_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !step)
        else $error("tick processed while result stage stalled");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the 8N1 UART transceiver. Every input transfer is one
// clock tick of the UART. A cycle-accurate shadow of the transmitter, receiver
// and receive FIFO predicts each tick's result, and every output transfer is
// compared field by field. The bit period is moved between phases over small
// values, including zero and one, and last set to the largest value. The
// receive line carries mostly well-formed serial frames, with some cut-off
// frames and noise mixed in. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        bit       tx_start;
        bit [7:0] tx_data;
        bit       rx_line;
        bit       rx_pop;
    } tick_t;

    typedef struct {
        bit       tx_line;
        bit       tx_busy;
        bit       tx_accepted;
        bit [7:0] rx_data;
        bit       rx_valid;
        bit [4:0] rx_count;
        bit       rx_overflow;
    } tick_result_t;

    class uart_mirror;
        bit [15:0]    period;
        bit [15:0]    tx_timer;
        bit [7:0]     tx_shift;
        bit [3:0]     tx_bits_left;
        bit           tx_active;
        bit           tx_level;
        bit           rx_active;
        bit [16:0]    rx_timer;
        bit [7:0]     rx_shift;
        bit [3:0]     rx_bits_got;
        bit           rx_prev;
        bit [7:0]     rx_store[$];
        tick_result_t tick_results[$];
        int           errors;

        function void reset();
            period       = u8n1_pkg::PERIOD_RESET;
            tx_timer     = 0;
            tx_shift     = 0;
            tx_bits_left = 0;
            tx_active    = 0;
            tx_level     = 1;
            rx_active    = 0;
            rx_timer     = 0;
            rx_shift     = 0;
            rx_bits_got  = 0;
            rx_prev      = 1;
            rx_store.delete();
            tick_results.delete();
        endfunction

        // one UART tick; the expected result is queued
        function void take_tick(tick_t t);
            tick_result_t r;
            bit           have_byte;
            r = '{default: 0};
            have_byte = 0;

            // a request is judged on the busy state at the start of the tick
            if (!tx_active) begin
                if (t.tx_start) begin
                    r.tx_accepted = 1;
                    tx_active     = 1;
                    tx_shift      = t.tx_data;
                    tx_bits_left  = u8n1_pkg::TX_FRAME_BITS;
                    tx_level      = 0;
                    tx_timer      = period;
                end
            end
            else if (tx_timer > 1)
                tx_timer--;
            else if (tx_bits_left > 1) begin
                tx_level = tx_shift[0];
                tx_shift = tx_shift >> 1;
                tx_bits_left--;
                tx_timer = period;
            end
            else if (tx_bits_left == 1) begin
                tx_level     = 1;
                tx_bits_left = 0;
                tx_timer     = period;
            end
            else begin
                tx_active = 0;
                tx_level  = 1;
            end

            if (rx_active) begin
                if (rx_timer > 1)
                    rx_timer--;
                else begin
                    rx_shift = {t.rx_line, rx_shift[7:1]};
                    rx_bits_got++;
                    rx_timer = period;
                    if (rx_bits_got >= u8n1_pkg::RX_DATA_BITS) begin
                        have_byte = 1;
                        rx_active = 0;
                    end
                end
            end
            else if (rx_prev && !t.rx_line) begin
                // first sample lands mid bit 0
                rx_active   = 1;
                rx_timer    = {1'b0, period} + (period >> 1);
                rx_bits_got = 0;
                rx_shift    = 0;
            end
            rx_prev = t.rx_line;

            // pop before push, so a popped full FIFO still takes the new byte
            if (t.rx_pop && rx_store.size() > 0) begin
                r.rx_data  = rx_store.pop_front();
                r.rx_valid = 1;
            end
            if (have_byte) begin
                if (rx_store.size() >= u8n1_pkg::RX_FIFO_DEPTH)
                    r.rx_overflow = 1;
                else
                    rx_store.push_back(rx_shift);
            end

            r.tx_line  = tx_level;
            r.tx_busy  = tx_active;
            r.rx_count = 5'(rx_store.size());
            tick_results.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [u8n1_pkg::OUT_TDATA_W-1:0] d);
            tick_result_t e;
            if (tick_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, d);
                errors++;
                return;
            end
            e = tick_results.pop_front();
            compare("tx_line", e.tx_line, d[0]);
            compare("tx_busy", e.tx_busy, d[1]);
            compare("tx_accepted", e.tx_accepted, d[2]);
            compare("rx_byte", e.rx_data, d[10:3]);
            compare("rx_valid", e.rx_valid, d[11]);
            compare("rx_count", e.rx_count, d[16:12]);
            compare("rx_overflow", e.rx_overflow, d[17]);
            compare("tdata pad", 0, d[23:18]);
        endfunction
    endclass

    localparam logic [u8n1_pkg::PADDR_W-1:0] BIT_PERIOD_ADDR =
        {u8n1_pkg::REG_BIT_PERIOD, 2'b00};
    localparam int                           PHASES = 10;

    logic                                clk;
    logic                                rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    // [0] tx_start, [8:1] tx_byte, [9] rx_line, [10] rx_pop, [15:11] zero
    logic [u8n1_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    // [0] tx_line, [1] tx_busy, [2] tx_accepted, [10:3] rx_byte, [11] rx_valid,
    // [16:12] rx_count, [17] rx_overflow, [23:18] zero
    logic [u8n1_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [u8n1_pkg::PADDR_W-1:0]        paddr;
    logic [31:0]                         pwdata;
    logic [31:0]                         prdata;
    logic                                pready;

    uart_mirror mirror = new();
    bit         line_plan[$];
    bit         src_quiet;
    bit         sink_quiet;
    int         sink_hold;

    int phase_period[PHASES] = '{3, 0, 1, 2, 4, 6, 1, 2, 9, 5};
    int phase_items[PHASES]  = '{180, 150, 200, 180, 180, 200, 200, 180, 180, 200};
    int phase_pop[PHASES]    = '{30, 0, 0, 30, 50, 10, 0, 90, 25, 40};
    bit phase_quiet[PHASES]  = '{0, 0, 0, 1, 0, 0, 0, 0, 1, 0};

    uart_8n1_transceiver i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic tick_t make_tick(bit start, bit [7:0] data, bit line, bit pop);
        tick_t t;
        t.tx_start = start;
        t.tx_data  = data;
        t.rx_line  = line;
        t.rx_pop   = pop;
        return t;
    endfunction

    // serial frame at 'ticks' per bit; nbits < 8 gives a cut-off frame
    function automatic void push_frame(bit [7:0] data, int nbits, int ticks);
        repeat (ticks) line_plan.push_back(1'b0);
        for (int b = 0; b < nbits; b++)
            repeat (ticks) line_plan.push_back(data[b]);
        if (nbits == 8)
            repeat (ticks) line_plan.push_back(1'b1);
    endfunction

    function automatic void plan_line();
        int ticks;
        int r;
        ticks = (mirror.period < 2) ? 1 : int'(mirror.period);
        r = $urandom_range(99);
        if (r < 80) begin
            push_frame(8'($urandom_range(255)), 8, ticks);
            repeat ($urandom_range(0, 3 * ticks)) line_plan.push_back(1'b1);
        end
        else if (r < 90)
            push_frame(8'($urandom_range(255)), $urandom_range(0, 7), ticks);
        else
            repeat ($urandom_range(1, 8)) line_plan.push_back(1'($urandom_range(1)));
    endfunction

    function automatic tick_t random_tick(int pop_pct);
        if (line_plan.size() == 0)
            plan_line();
        return make_tick($urandom_range(99) < 30, 8'($urandom_range(255)),
                         line_plan.pop_front(), $urandom_range(99) < pop_pct);
    endfunction

    function automatic int pick_gap();
        int r;
        if (src_quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_tick(tick_t t);
        repeat (pick_gap())
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, t.rx_pop, t.rx_line, t.tx_data, t.tx_start};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        mirror.take_tick(t);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (mirror.tick_results.size() != 0)
            @(posedge clk);
    endtask

    // write then read back; only with nothing in flight
    task automatic write_bit_period(bit [15:0] value);
        wait_results_drained();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = BIT_PERIOD_ADDR;
        pwdata  = {16'b0, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        mirror.period = value;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        mirror.compare("bit_period readback", value, prdata[15:0]);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // receiver side: random stalls, mostly short
    initial
    begin
        int r;
        m_axis_tready = 1'b0;
        sink_hold     = 0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0) begin
                m_axis_tready = 1'b0;
                sink_hold--;
            end
            else if (sink_quiet)
                m_axis_tready = 1'b1;
            else begin
                r = $urandom_range(99);
                if (r < 80)
                    m_axis_tready = 1'b1;
                else if (r < 95) begin
                    m_axis_tready = 1'b0;
                    sink_hold     = $urandom_range(0, 2);
                end
                else begin
                    m_axis_tready = 1'b0;
                    sink_hold     = $urandom_range(9, 39);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            mirror.check_result(m_axis_tdata);
    end

    initial
    begin
        #6000000;
        $display("FAIL uart_8n1_transceiver");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        src_quiet     = 1'b0;
        sink_quiet    = 1'b0;
        mirror.reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset state at the default period, pop on empty FIFO
        send_tick(make_tick(0, 8'h00, 1, 0));
        send_tick(make_tick(0, 8'hFF, 1, 1));

        // one-tick bits: start every tick (refusals, refusal on the last busy
        // tick, re-accept), receive 0x00 then 0xFF back to back, pop both
        write_bit_period(1);
        line_plan.delete();
        push_frame(8'h00, 8, 1);
        push_frame(8'hFF, 8, 1);
        for (int k = 0; k < 22; k++)
            send_tick(make_tick(1, (k % 3 == 0) ? 8'hFF : (k % 3 == 1) ? 8'h00 :
                                8'($urandom_range(255)),
                                (k < 20) ? line_plan.pop_front() : 1'b1, k >= 19));

        // phase writes can land mid-frame: running countdowns keep their values
        for (int p = 0; p < PHASES; p++) begin
            write_bit_period(16'(phase_period[p]));
            src_quiet  = phase_quiet[p];
            sink_quiet = phase_quiet[p];
            for (int k = 0; k < phase_items[p]; k++) begin
                if (p == 4 && k == phase_items[p] / 2)
                    wait_results_drained();
                send_tick(random_tick(phase_pop[p]));
            end
        end

        // largest period: only the first ticks of a frame are reachable
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        write_bit_period(16'hFFFF);
        line_plan.delete();
        for (int k = 0; k < 20; k++)
            send_tick(make_tick(k % 4 == 0, 8'($urandom_range(255)),
                                !(k >= 3 && k < 13), 1'(k % 2)));

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (mirror.tick_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0", $time,
                     mirror.tick_results.size());
            mirror.errors++;
        end
        if (mirror.errors == 0)
            $display("PASS uart_8n1_transceiver");
        else
            $display("FAIL uart_8n1_transceiver");
        $finish;
    end

endmodule
